[rtl/arat_pkg.sv]
// Shared types and constants for the ack range tracker.
// Holds the transfer payload structs, the op codes, the sequencer states
// and the request and response of the shared subtractor. No dependencies.
`default_nettype none

package arat_pkg;

    localparam int NUM_W      = 62;
    localparam int CNT_W      = 6;
    localparam int RESULT_CAP = 32;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REPORT = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [NUM_W-1:0] pkt_num;
        logic [CNT_W-1:0] max_ranges;
    } t_in_item;

    typedef struct packed {
        logic [NUM_W-1:0] range_low;
        logic [NUM_W-1:0] range_high;
        logic             present;
        logic             last_range;
    } t_out_item;

    typedef struct packed {
        logic [NUM_W-1:0] a;
        logic [NUM_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [NUM_W-1:0] diff;
        logic             borrow;
    } t_alu_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUB1,
        ST_SUB2,
        ST_CMP,
        ST_SLIDE,
        ST_CLEAR,
        ST_RD_ADDR,
        ST_RD_EVAL,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

[rtl/arat_alu.sv]
// Shared 62-bit subtractor with borrow, used for the packet-number compares and steps.
// Depends on arat_pkg for the request and response structs.
`default_nettype none

module arat_alu
    import arat_pkg::*;
(
    input  wire t_alu_req i_req,
    output t_alu_rsp      o_rsp
);

    logic [NUM_W:0] w_sub;

    assign w_sub        = {1'b0, i_req.a} - {1'b0, i_req.b};
    assign o_rsp.diff   = w_sub[NUM_W-1:0];
    assign o_rsp.borrow = w_sub[NUM_W];

endmodule

`default_nettype wire

[rtl/arat_bitmap.sv]
// Received-number bitmap: one write port and one registered read port.
// Depends on nothing but its WINDOW parameter.
`default_nettype none

module arat_bitmap #(
    parameter int WINDOW = 256,
    localparam int SW    = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [SW-1:0] i_waddr,
    input  wire logic          i_wbit,
    input  wire logic [SW-1:0] i_raddr,
    output logic               o_rbit
);

    logic r_mem [WINDOW];
    logic r_rbit;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wbit;
        end
        r_rbit <= r_mem[i_raddr];
    end

    assign o_rbit = r_rbit;

endmodule

`default_nettype wire

[rtl/arat_ctrl.sv]
// Sequencer of the ack range tracker: add, slide, clear sweep, report walk
// and range emission, with the found-range store. Drives the shared
// subtractor and the bitmap. Depends on arat_pkg.
`default_nettype none

module arat_ctrl
    import arat_pkg::*;
#(
    parameter int WINDOW     = 256,
    parameter int MAX_RANGES = 32,
    localparam int SW        = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire t_in_item      i_in_data,
    output logic               o_in_stall,
    output t_alu_req           o_alu_req,
    input  wire t_alu_rsp      i_alu_rsp,
    output logic               o_bm_we,
    output logic [SW-1:0]      o_bm_waddr,
    output logic               o_bm_wbit,
    output logic [SW-1:0]      o_bm_raddr,
    input  wire logic          i_bm_rbit,
    output logic               o_res_valid,
    output t_out_item          o_res,
    input  wire logic          i_res_stall
);

    localparam int CAP = (MAX_RANGES < RESULT_CAP) ? MAX_RANGES : RESULT_CAP;
    localparam int IW  = (CAP > 1) ? $clog2(CAP) : 1;
    localparam logic [SW-1:0]    LAST_SLOT = SW'(WINDOW - 1);
    localparam logic [SW:0]      W_EXT     = (SW + 1)'(WINDOW);
    localparam logic [CNT_W-1:0] CAP_CNT   = CNT_W'(CAP);
    localparam logic [NUM_W-1:0] W_NUM     = NUM_W'(WINDOW);

    t_state           r_state,   n_state;
    logic [NUM_W-1:0] r_largest, n_largest;
    logic             r_any,     n_any;
    logic [SW-1:0]    r_lslot,   n_lslot;
    logic [NUM_W-1:0] r_pn,      n_pn;
    logic [NUM_W-1:0] r_t,       n_t;
    logic             r_le,      n_le;
    logic [SW-1:0]    r_slide,   n_slide;
    logic [SW-1:0]    r_addr,    n_addr;
    logic [NUM_W-1:0] r_num,     n_num;
    logic [SW-1:0]    r_slot,    n_slot;
    logic [SW-1:0]    r_k,       n_k;
    logic [CNT_W-1:0] r_limit,   n_limit;
    logic [CNT_W-1:0] r_rcount,  n_rcount;
    logic [CNT_W-1:0] r_e,       n_e;
    logic             r_empty,   n_empty;
    logic             r_in_run,  n_in_run;
    logic [NUM_W-1:0] r_lo [CAP];
    logic [NUM_W-1:0] r_hi [CAP];

    logic             w_lo_we, w_hi_we;
    logic [IW-1:0]    w_widx;
    logic [SW:0]      w_back;
    logic [SW-1:0]    w_inc_slot, w_dec_slot;
    logic [CNT_W-1:0] w_want, w_rc1, w_fin;
    logic             w_last_step, w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_largest <= '0;
            r_any     <= 1'b0;
            r_lslot   <= '0;
        end else begin
            r_state   <= n_state;
            r_largest <= n_largest;
            r_any     <= n_any;
            r_lslot   <= n_lslot;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pn     <= n_pn;
        r_t      <= n_t;
        r_le     <= n_le;
        r_slide  <= n_slide;
        r_addr   <= n_addr;
        r_num    <= n_num;
        r_slot   <= n_slot;
        r_k      <= n_k;
        r_limit  <= n_limit;
        r_rcount <= n_rcount;
        r_e      <= n_e;
        r_empty  <= n_empty;
        r_in_run <= n_in_run;
        if (w_lo_we) begin
            r_lo[w_widx] <= r_num;
        end
        if (w_hi_we) begin
            r_hi[w_widx] <= r_num;
        end
    end

    assign w_inc_slot = (r_lslot == LAST_SLOT) ? '0 : r_lslot + 1'b1;
    assign w_dec_slot = (r_slot == '0) ? LAST_SLOT : r_slot - 1'b1;
    assign w_back     = ({1'b0, r_lslot} >= {1'b0, r_t[SW-1:0]})
                      ? {1'b0, r_lslot} - {1'b0, r_t[SW-1:0]}
                      : {1'b0, r_lslot} + W_EXT - {1'b0, r_t[SW-1:0]};
    assign w_want     = (i_in_data.max_ranges == '0) ? CNT_W'(1) :
                        (i_in_data.max_ranges > CAP_CNT) ? CAP_CNT : i_in_data.max_ranges;
    assign w_last_step = (r_k == LAST_SLOT) || (r_num == '0);
    assign w_rc1       = r_rcount + 1'b1;
    assign w_widx      = r_rcount[IW-1:0];

    always_comb begin
        n_state    = r_state;
        n_largest  = r_largest;
        n_any      = r_any;
        n_lslot    = r_lslot;
        n_pn       = r_pn;
        n_t        = r_t;
        n_le       = r_le;
        n_slide    = r_slide;
        n_addr     = r_addr;
        n_num      = r_num;
        n_slot     = r_slot;
        n_k        = r_k;
        n_limit    = r_limit;
        n_rcount   = r_rcount;
        n_e        = r_e;
        n_empty    = r_empty;
        n_in_run   = r_in_run;
        o_alu_req  = '{a: r_largest, b: r_pn};
        o_bm_we    = 1'b0;
        o_bm_waddr = r_lslot;
        o_bm_wbit  = 1'b0;
        o_bm_raddr = r_slot;
        o_res_valid = 1'b0;
        o_res      = '{range_low: r_lo[r_e[IW-1:0]], range_high: r_hi[r_e[IW-1:0]],
                       present: 1'b1, last_range: (r_e == '0)};
        w_lo_we    = 1'b0;
        w_hi_we    = 1'b0;
        w_fin      = r_rcount;
        w_done     = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_data.op)
                        OP_ADD: begin
                            n_pn    = i_in_data.pkt_num;
                            n_state = ST_SUB1;
                        end
                        OP_REPORT: begin
                            n_limit  = w_want;
                            n_num    = r_largest;
                            n_slot   = r_lslot;
                            n_k      = '0;
                            n_rcount = '0;
                            n_in_run = 1'b0;
                            n_empty  = !r_any;
                            n_e      = '0;
                            n_state  = r_any ? ST_RD_ADDR : ST_EMIT;
                        end
                        OP_CLEAR: begin
                            n_any     = 1'b0;
                            n_largest = '0;
                            n_lslot   = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SUB1: begin
                n_t  = i_alu_rsp.diff;
                n_le = !i_alu_rsp.borrow;
                if (!r_any) begin
                    n_addr  = LAST_SLOT;
                    n_state = ST_CLEAR;
                end else if (i_alu_rsp.borrow) begin
                    n_state = ST_SUB2;
                end else begin
                    n_state = ST_CMP;
                end
            end
            ST_SUB2: begin
                o_alu_req = '{a: r_pn, b: r_largest};
                n_t       = i_alu_rsp.diff;
                n_state   = ST_CMP;
            end
            ST_CMP: begin
                o_alu_req = '{a: r_t, b: W_NUM};
                n_state   = ST_IDLE;
                if (r_le) begin
                    if (i_alu_rsp.borrow) begin
                        o_bm_we    = 1'b1;
                        o_bm_waddr = w_back[SW-1:0];
                        o_bm_wbit  = 1'b1;
                    end
                end else if (i_alu_rsp.borrow) begin
                    n_slide = r_t[SW-1:0];
                    n_state = ST_SLIDE;
                end else begin
                    n_addr  = LAST_SLOT;
                    n_state = ST_CLEAR;
                end
            end
            ST_SLIDE: begin
                o_bm_we    = 1'b1;
                o_bm_waddr = w_inc_slot;
                o_bm_wbit  = (r_slide == SW'(1));
                n_lslot    = w_inc_slot;
                n_slide    = r_slide - 1'b1;
                if (r_slide == SW'(1)) begin
                    n_largest = r_pn;
                    n_state   = ST_IDLE;
                end
            end
            ST_CLEAR: begin
                o_bm_we    = 1'b1;
                o_bm_waddr = r_addr;
                o_bm_wbit  = (r_addr == '0);
                n_addr     = r_addr - 1'b1;
                if (r_addr == '0) begin
                    n_largest = r_pn;
                    n_any     = 1'b1;
                    n_lslot   = '0;
                    n_state   = ST_IDLE;
                end
            end
            ST_RD_ADDR: begin
                n_state = ST_RD_EVAL;
            end
            ST_RD_EVAL: begin
                o_alu_req = '{a: r_num, b: NUM_W'(1)};
                if (i_bm_rbit) begin
                    w_lo_we = 1'b1;
                    w_hi_we = !r_in_run;
                    n_in_run = 1'b1;
                    w_done  = w_last_step;
                    w_fin   = w_rc1;
                end else if (r_in_run) begin
                    n_in_run = 1'b0;
                    n_rcount = w_rc1;
                    w_done   = w_last_step || (w_rc1 >= r_limit);
                    w_fin    = w_rc1;
                end else begin
                    w_done = w_last_step;
                end
                if (w_done) begin
                    n_rcount = w_fin;
                    n_e      = w_fin - 1'b1;
                    n_empty  = (w_fin == '0);
                    n_state  = ST_EMIT;
                end else begin
                    n_num   = i_alu_rsp.diff;
                    n_slot  = w_dec_slot;
                    n_k     = r_k + 1'b1;
                    n_state = ST_RD_ADDR;
                end
            end
            ST_EMIT: begin
                o_res_valid = 1'b1;
                if (r_empty) begin
                    o_res = '{range_low: '0, range_high: '0, present: 1'b0,
                              last_range: 1'b1};
                end
                if (!i_res_stall) begin
                    if (r_empty || r_e == '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_e = r_e - 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

`default_nettype wire

[rtl/ack_range_tracker.sv]
// Ack range tracker top level: sequencer, shared subtractor, bitmap and
// the output register. Depends on arat_pkg, arat_alu, arat_bitmap, arat_ctrl.
//
// The block keeps a bitmap of the last WINDOW packet numbers ending at the
// largest one seen and takes one item at a time; o_in_stall is high while it
// works. A clear leaves o_in_stall low. An add runs ST_SUB1 and ST_CMP when
// the number lies at or below the largest, adds ST_SUB2 and one ST_SLIDE step
// per number of rise when it raises the largest by less than WINDOW, and else
// sweeps the whole bitmap in ST_CLEAR (after ST_SUB1 on the first add). A
// report reads and judges each number walked in ST_RD_ADDR and ST_RD_EVAL (at
// most WINDOW numbers, fewer when the range limit or number zero is reached),
// then gives one range per cycle while the output is not stalled, ascending,
// the last marked by last_range; an empty tracker gives a single result with
// present low. It has a single 62-bit subtractor and registered bitmap reads.
`default_nettype none

module ack_range_tracker
    import arat_pkg::*;
#(
    parameter int WINDOW     = 256,
    parameter int MAX_RANGES = 32
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire t_in_item i_in_data,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output t_out_item     o_out_data,
    input  wire logic     i_out_stall
);

    localparam int SW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    t_alu_req      w_alu_req;
    t_alu_rsp      w_alu_rsp;
    logic          w_bm_we;
    logic [SW-1:0] w_bm_waddr;
    logic          w_bm_wbit;
    logic [SW-1:0] w_bm_raddr;
    logic          w_bm_rbit;
    logic          w_res_valid;
    t_out_item     w_res;
    logic          w_res_stall;

    logic          r_ovalid;
    t_out_item     r_odata;

    arat_alu u_alu (
        .i_req (w_alu_req),
        .o_rsp (w_alu_rsp)
    );

    arat_bitmap #(
        .WINDOW (WINDOW)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (w_bm_we),
        .i_waddr (w_bm_waddr),
        .i_wbit  (w_bm_wbit),
        .i_raddr (w_bm_raddr),
        .o_rbit  (w_bm_rbit)
    );

    arat_ctrl #(
        .WINDOW     (WINDOW),
        .MAX_RANGES (MAX_RANGES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_alu_req   (w_alu_req),
        .i_alu_rsp   (w_alu_rsp),
        .o_bm_we     (w_bm_we),
        .o_bm_waddr  (w_bm_waddr),
        .o_bm_wbit   (w_bm_wbit),
        .o_bm_raddr  (w_bm_raddr),
        .i_bm_rbit   (w_bm_rbit),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_stall (w_res_stall)
    );

    assign w_res_stall = r_ovalid && i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (!w_res_stall) begin
            r_ovalid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_res_stall) begin
            r_odata <= w_res;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

endmodule

`default_nettype wire

[rtl/arat_checker.sv]
// Port-level checks for the ack range tracker, bound to the top level.
// Depends on arat_pkg and ack_range_tracker.
`default_nettype none

module arat_checker
    import arat_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire t_in_item  i_in_data,
    input wire logic      o_in_stall,
    input wire logic      o_out_valid,
    input wire t_out_item o_out_data,
    input wire logic      i_out_stall
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_report_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.op == OP_REPORT |=> o_in_stall)
        else $error("report did not hold off input");

    a_clear_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.op == OP_CLEAR |=> !o_in_stall)
        else $error("clear held off input");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.present |-> o_out_data.last_range)
        else $error("empty result not marked last");

    a_range_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.present |->
            o_out_data.range_low <= o_out_data.range_high)
        else $error("range bounds out of order");

endmodule

bind ack_range_tracker arat_checker u_arat_checker (.*);

`default_nettype wire
